FILE: rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP cache table
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);

	localparam int CMD_W    = 3;
	localparam int IP_W     = 32;
	localparam int MAC_W    = 48;
	localparam int IFC_W    = 4;
	localparam int OP_W     = 16;
	localparam int STATUS_W = 3;

	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 56;

	localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LEARN  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

	localparam logic [OP_W-1:0] ARP_OP_REPLY = 16'd2;

	localparam logic [STATUS_W-1:0] STS_DONE     = 3'd0;
	localparam logic [STATUS_W-1:0] STS_DUP      = 3'd1;
	localparam logic [STATUS_W-1:0] STS_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd3;
	localparam logic [STATUS_W-1:0] STS_IGNORED  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic needs_scan;
		logic last;
		logic out_free;
	} dp_status_t;

endpackage

FILE: rtl/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// arpc_ctrl
// Command sequencer: accept, slot scan, commit and result hand-off
// ----------------------------------------------------------------------------
module arpc_ctrl
	import arpc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t dp_sts,
	output ctrl_cmd_t  ctrl
);

	ctrl_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = dp_sts.needs_scan ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (dp_sts.last) begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (dp_sts.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		ctrl.load   = 1'b0;
		ctrl.step   = 1'b0;
		ctrl.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ctrl.load = in_valid;
			end
			ST_SCAN: begin
				ctrl.step = 1'b1;
			end
			ST_FINISH: begin
				ctrl.commit = dp_sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/arpc_dp.sv
// ----------------------------------------------------------------------------
// arpc_dp
// Slot storage, key scan, result decision and output register
// ----------------------------------------------------------------------------
module arpc_dp
	import arpc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_cmd_t           ctrl,
	output dp_status_t          dp_sts,
	input  logic [CMD_W-1:0]    in_cmd,
	input  logic [IP_W-1:0]     in_ip,
	input  logic [MAC_W-1:0]    in_mac,
	input  logic [IFC_W-1:0]    in_ifc,
	input  logic [OP_W-1:0]     in_op,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] out_status,
	output logic                out_hit,
	output logic [MAC_W-1:0]    out_mac,
	output logic [IFC_W-1:0]    out_ifc
);

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [IP_W-1:0]          slot_ip_q  [TABLE_ENTRIES];
	logic [MAC_W-1:0]         slot_mac_q [TABLE_ENTRIES];
	logic [IFC_W-1:0]         slot_ifc_q [TABLE_ENTRIES];

	logic [CMD_W-1:0] cmd_q;
	logic [IP_W-1:0]  ip_q;
	logic [MAC_W-1:0] mac_q;
	logic [IFC_W-1:0] ifc_q;
	logic [OP_W-1:0]  op_q;

	logic [IDX_W-1:0] idx_q;
	logic             found_q;
	logic [IDX_W-1:0] found_idx_q;
	logic [MAC_W-1:0] found_mac_q;
	logic [IFC_W-1:0] found_ifc_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_hit_q;
	logic [MAC_W-1:0]    out_mac_q;
	logic [IFC_W-1:0]    out_ifc_q;

	logic                entry_match;
	logic                entry_free;
	logic [STATUS_W-1:0] res_status;
	logic                res_hit;
	logic [MAC_W-1:0]    res_mac;
	logic [IFC_W-1:0]    res_ifc;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	logic                del_en;
	logic                clr_all;

	always_comb begin
		dp_sts.needs_scan = (in_cmd inside {CMD_LOOKUP, CMD_ADD, CMD_DELETE})
			|| (in_cmd == CMD_LEARN && in_op == ARP_OP_REPLY);
		dp_sts.last       = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
		dp_sts.out_free   = !out_valid_q || out_ready;
	end

	assign entry_match = valid_q[idx_q] && (slot_ip_q[idx_q] == ip_q);
	assign entry_free  = !valid_q[idx_q];

	// captured command
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= in_cmd;
			ip_q  <= in_ip;
			mac_q <= in_mac;
			ifc_q <= in_ifc;
			op_q  <= in_op;
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (ctrl.load) begin
			idx_q   <= '0;
			found_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (ctrl.step) begin
			idx_q <= idx_q + 1'b1;
			if (entry_match && !found_q) begin
				found_q <= 1'b1;
			end
			if (entry_free && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			if (entry_match && !found_q) begin
				found_idx_q <= idx_q;
				found_mac_q <= slot_mac_q[idx_q];
				found_ifc_q <= slot_ifc_q[idx_q];
			end
			if (entry_free && !free_q) begin
				free_idx_q <= idx_q;
			end
		end
	end

	// result decision
	always_comb begin
		res_status = STS_DONE;
		res_hit    = 1'b0;
		res_mac    = '0;
		res_ifc    = '0;
		wr_en      = 1'b0;
		wr_idx     = free_idx_q;
		del_en     = 1'b0;
		clr_all    = 1'b0;
		case (cmd_q)
			CMD_LOOKUP: begin
				if (found_q) begin
					res_hit = 1'b1;
					res_mac = found_mac_q;
					res_ifc = found_ifc_q;
				end else begin
					res_status = STS_NOTFOUND;
				end
			end
			CMD_ADD, CMD_LEARN: begin
				if (cmd_q == CMD_LEARN && op_q != ARP_OP_REPLY) begin
					res_status = STS_IGNORED;
				end else if (found_q) begin
					res_hit = 1'b1;
					wr_idx  = found_idx_q;
					if (found_mac_q == mac_q && found_ifc_q == ifc_q) begin
						res_status = STS_DUP;
					end else begin
						wr_en = 1'b1;
					end
				end else if (free_q) begin
					wr_en = 1'b1;
				end else begin
					res_status = STS_FULL;
				end
			end
			CMD_DELETE: begin
				if (found_q) begin
					res_hit = 1'b1;
					del_en  = 1'b1;
				end else begin
					res_status = STS_NOTFOUND;
				end
			end
			CMD_CLEAR: begin
				clr_all = 1'b1;
			end
			default: begin
				res_status = STS_IGNORED;
			end
		endcase
	end

	// slot table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctrl.commit) begin
			if (clr_all) begin
				valid_q <= '0;
			end else if (del_en) begin
				valid_q[found_idx_q] <= 1'b0;
			end else if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit && wr_en) begin
			slot_ip_q[wr_idx]  <= ip_q;
			slot_mac_q[wr_idx] <= mac_q;
			slot_ifc_q[wr_idx] <= ifc_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			out_status_q <= res_status;
			out_hit_q    <= res_hit;
			out_mac_q    <= res_mac;
			out_ifc_q    <= res_ifc;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_hit    = out_hit_q;
	assign out_mac    = out_mac_q;
	assign out_ifc    = out_ifc_q;

endmodule

FILE: rtl/arp_cache_table_top.sv
// ----------------------------------------------------------------------------
// arp_cache_table_top
// ARP cache: IPv4 key to MAC address and outgoing interface
// ----------------------------------------------------------------------------
// One command per input transfer, one result transfer per command. Lookup,
// add, learn and delete go through accept, a scan of every table slot for
// the key and a free slot (16 slots through a single compare unit), and
// commit, which waits until the output register can take the result. Clear,
// unknown commands and learn from a non-reply packet skip the scan.
// The next command is accepted once the previous one has been committed,
// even while its result still waits in the output register. The slot valid
// bits are cleared by reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module arp_cache_table_top
	import arpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// ip_addr[31:0], mac_addr[79:32], interface_index[83:80], arp_operation[99:84]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// command[2:0]
	input  logic [CMD_W-1:0]      s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// hit[0], found_mac[48:1], found_interface[52:49]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// status[2:0]
	output logic [STATUS_W-1:0]   m_axis_tuser
);

	ctrl_cmd_t        ctrl;
	dp_status_t       dp_sts;
	logic             out_hit;
	logic [MAC_W-1:0] out_mac;
	logic [IFC_W-1:0] out_ifc;

	arpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.dp_sts   (dp_sts),
		.ctrl     (ctrl)
	);

	arpc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.dp_sts     (dp_sts),
		.in_cmd     (s_axis_tuser),
		.in_ip      (s_axis_tdata[31:0]),
		.in_mac     (s_axis_tdata[79:32]),
		.in_ifc     (s_axis_tdata[83:80]),
		.in_op      (s_axis_tdata[99:84]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_hit    (out_hit),
		.out_mac    (out_mac),
		.out_ifc    (out_ifc)
	);

	assign m_axis_tdata = {3'b000, out_ifc, out_mac, out_hit};

endmodule
